>>> rtl/can_signal_unpacker_macros.svh
`ifndef CAN_SIGNAL_UNPACKER_MACROS_SVH
`define CAN_SIGNAL_UNPACKER_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define CSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/csu_pkg.sv
package csu_pkg;

  // default sizes
  localparam int MSG_SLOTS      = 16;
  localparam int VARS_PER_MSG   = 8;
  localparam int VAR_STORE_SIZE = 256;
  localparam int MAX_RESULTS    = 8;

  // field widths
  localparam int REQ_W       = 2;
  localparam int ID_W        = 29;
  localparam int DLC_W       = 4;
  localparam int DATA_W      = 64;
  localparam int SLOT_IDX_W  = 4;
  localparam int POS_W       = 3;
  localparam int CNT_IN_W    = 4;
  localparam int START_W     = 6;
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 3;
  localparam int VIDX_W      = 8;
  localparam int VAL_W       = 32;
  localparam int VAR_BASE_W  = 8;
  localparam int MSG_COUNT_W = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_COUNT = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_FRAME  = 2'd0,
    REQ_MSG_WR = 2'd1,
    REQ_VAR_WR = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_VAR_WRITTEN = 3'd0,
    ST_NO_MATCH    = 3'd1,
    ST_TOO_SHORT   = 3'd2,
    ST_NOTHING     = 3'd3,
    ST_TABLE_DONE  = 3'd4
  } status_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_BOOL  = 3'd0,
    KIND_INT8  = 3'd1,
    KIND_INT16 = 3'd2,
    KIND_INT32 = 3'd3,
    KIND_FLOAT = 3'd4
  } kind_e;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [ID_W-1:0]       frame_id;
    logic [DLC_W-1:0]      frame_dlc;
    logic [DATA_W-1:0]     frame_data;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [POS_W-1:0]      var_position;
    logic [ID_W-1:0]       entry_id;
    logic [DLC_W-1:0]      entry_min_dlc;
    logic [CNT_IN_W-1:0]   entry_var_count;
    logic [START_W-1:0]    entry_start_bit;
    logic [KIND_W-1:0]     entry_type;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VIDX_W-1:0]   var_index;
    logic [VAL_W-1:0]    var_value;
    logic [KIND_W-1:0]   var_kind;
    logic                last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    srch_open;
    logic    srch_step;
    logic    hit_load;
    logic    var_step;
    logic    stage;
    logic    finish;
    status_e resp_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic srch_end;
    logic match;
    logic too_short;
    logic emit_end;
    logic kind_ok;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/csu_stream_if.sv
interface csu_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/can_signal_unpacker.sv
// channel   dir  beat                          payload
// req_i     in   frame or table write          csu_pkg::req_t
// res_o     out  one store write or a status   csu_pkg::res_t
// cfg       in   register write, no handshake  cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// a table write or unknown request passes S_DONE on the way to its result beat
// a frame ends after k slots passed in the search when it misses or is too short,
//   and on a match goes on to inspect m descriptors; the search reads one slot a
//   cycle through the message table read port, and each descriptor is read in
//   S_VRD and handled in S_VEMIT through the descriptor table read port
// reset is asynchronous and active low and clears the control registers only, the
//   tables and payload registers hold nothing defined until written
// the result register lets the next item in while a beat waits; a stalled res_o
//   holds the emission or the closing beat until the beat is taken

module can_signal_unpacker #(
  parameter int MSG_SLOTS      = csu_pkg::MSG_SLOTS,
  parameter int VARS_PER_MSG   = csu_pkg::VARS_PER_MSG,
  parameter int VAR_STORE_SIZE = csu_pkg::VAR_STORE_SIZE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [csu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [csu_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // request and result channels
  csu_stream_if.sink                     req_i,
  csu_stream_if.source                   res_o
);

  // command and status between sequencer and datapath
  csu_pkg::cmd_t cmd;
  csu_pkg::sts_t sts;
  csu_pkg::req_t req_data;
  csu_pkg::res_t res_data;
  logic          req_ready;
  logic          res_valid;

  assign req_data = req_i.data;

  // sequencer: search, emission and reply steps
  csu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_data.req_type),
    .req_ready_o (req_ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // tables, registers, extraction and the result register
  csu_datapath #(
    .MSG_SLOTS      (MSG_SLOTS),
    .VARS_PER_MSG   (VARS_PER_MSG),
    .VAR_STORE_SIZE (VAR_STORE_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_data_i  (req_data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .res_data_o  (res_data)
  );

  // ready only while waiting for a new beat
  assign req_i.ready = req_ready;
  assign res_o.valid = res_valid;
  assign res_o.data  = res_data;

endmodule

>>> rtl/csu_ctrl.sv
`include "can_signal_unpacker_macros.svh"

module csu_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic [csu_pkg::REQ_W-1:0]     req_type_i,
  output logic                          req_ready_o,
  output csu_pkg::cmd_t                 cmd_o,
  input  csu_pkg::sts_t                 sts_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FILL  = 6'b000010,
    S_SRCH  = 6'b000100,
    S_VRD   = 6'b001000,
    S_VEMIT = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  csu_pkg::status_e resp_q, resp_d;

  always_comb begin
    state_d          = state_q;
    resp_d           = resp_q;
    req_ready_o      = 1'b0;
    cmd_o            = '0;
    cmd_o.resp_status = resp_q;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          case (req_type_i)
            csu_pkg::REQ_FRAME: begin
              state_d = S_FILL;
            end
            csu_pkg::REQ_MSG_WR, csu_pkg::REQ_VAR_WR: begin
              resp_d  = csu_pkg::ST_TABLE_DONE;
              state_d = S_DONE;
            end
            default: begin
              resp_d  = csu_pkg::ST_NOTHING;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_FILL: begin
        cmd_o.srch_open = 1'b1;
        state_d         = S_SRCH;
      end
      S_SRCH: begin
        if (sts_i.srch_end) begin
          resp_d  = csu_pkg::ST_NO_MATCH;
          state_d = S_DONE;
        end else if (sts_i.match) begin
          cmd_o.hit_load = 1'b1;
          if (sts_i.too_short) begin
            resp_d  = csu_pkg::ST_TOO_SHORT;
            state_d = S_DONE;
          end else begin
            resp_d  = csu_pkg::ST_NOTHING;
            state_d = S_VRD;
          end
        end else begin
          cmd_o.srch_step = 1'b1;
        end
      end
      S_VRD: begin
        if (sts_i.emit_end) begin
          state_d = S_DONE;
        end else begin
          state_d = S_VEMIT;
        end
      end
      S_VEMIT: begin
        if (!sts_i.kind_ok) begin
          cmd_o.var_step = 1'b1;
          state_d        = S_VRD;
        end else if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.stage    = 1'b1;
          cmd_o.var_step = 1'b1;
          state_d        = S_VRD;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= csu_pkg::ST_NOTHING;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  `CSU_ASSERT_NXT(a_frame_to_fill, req_valid_i && req_ready_o && (req_type_i == csu_pkg::REQ_FRAME), state_q == S_FILL, "frame beat did not start the slot search")
  `CSU_ASSERT_IMP(a_stage_room, cmd_o.stage && sts_i.pend_valid, sts_i.out_free, "staged result would overwrite a waiting beat")

endmodule

>>> rtl/csu_datapath.sv
`include "can_signal_unpacker_macros.svh"

module csu_datapath #(
  parameter int MSG_SLOTS      = csu_pkg::MSG_SLOTS,
  parameter int VARS_PER_MSG   = csu_pkg::VARS_PER_MSG,
  parameter int VAR_STORE_SIZE = csu_pkg::VAR_STORE_SIZE
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [csu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [csu_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  csu_pkg::req_t                    req_data_i,
  input  csu_pkg::cmd_t                    cmd_i,
  output csu_pkg::sts_t                    sts_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output csu_pkg::res_t                    res_data_o
);

  localparam int SLOT_W    = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MSG_SLOTS + 2);
  localparam int VC_W      = $clog2(VARS_PER_MSG + 1);
  localparam int VAR_DEPTH = MSG_SLOTS * VARS_PER_MSG;
  localparam int VA_W      = (VAR_DEPTH > 1) ? $clog2(VAR_DEPTH) : 1;
  localparam int OFF_W     = $clog2((1 << csu_pkg::VAR_BASE_W) + VAR_DEPTH + VARS_PER_MSG);
  localparam int STORE_W   = $clog2(VAR_STORE_SIZE + 1);
  localparam int CMP_W     = (OFF_W > STORE_W) ? OFF_W : STORE_W;
  localparam int MSG_W     = csu_pkg::ID_W + csu_pkg::DLC_W + VC_W;
  localparam int VAR_W     = csu_pkg::START_W + csu_pkg::KIND_W;
  localparam int NW        = $clog2(csu_pkg::MAX_RESULTS + 1);

  // configuration registers
  logic [csu_pkg::VAR_BASE_W-1:0]  var_base_q;
  logic [csu_pkg::MSG_COUNT_W-1:0] msg_count_q;

  // latched frame
  logic [csu_pkg::ID_W-1:0]   frm_id_q;
  logic [csu_pkg::DLC_W-1:0]  frm_dlc_q;
  logic [csu_pkg::DATA_W-1:0] frm_data_q;

  // tables
  logic [MSG_W-1:0] msg_mem [MSG_SLOTS];
  logic [VAR_W-1:0] var_mem [VAR_DEPTH];
  logic [MSG_W-1:0] msg_rd_q;
  logic [VAR_W-1:0] var_rd_q;

  logic              msg_we, var_we;
  logic [SLOT_W-1:0] msg_wa, msg_ra;
  logic [MSG_W-1:0]  msg_wd;
  logic [VA_W-1:0]   var_wa, var_ra;
  logic [VC_W-1:0]   wr_cnt;

  // search and emission state
  logic [CNT_W-1:0]  srch_idx_q, srch_idx_d, cur_idx_q;
  logic [OFF_W-1:0]  offset_q, offset_d, target;
  logic [SLOT_W-1:0] hit_idx_q;
  logic [VC_W-1:0]   hit_cnt_q, v_q, v_d;
  logic [NW-1:0]     n_q, n_d;

  logic                         pend_valid_q, pend_valid_d;
  logic [csu_pkg::VIDX_W-1:0]   pend_idx_q;
  logic [csu_pkg::VAL_W-1:0]    pend_val_q;
  logic [csu_pkg::KIND_W-1:0]   pend_kind_q;

  logic          out_valid_q, out_valid_d, out_free;
  csu_pkg::res_t out_q, out_d;

  logic [csu_pkg::ID_W-1:0]   rd_id;
  logic [csu_pkg::DLC_W-1:0]  rd_dlc;
  logic [VC_W-1:0]            rd_cnt;
  logic [csu_pkg::DATA_W-1:0] shifted;
  logic [csu_pkg::VAL_W-1:0]  ext_val;
  logic                       kind_ok;

  // table write ports, taken from the accepted beat
  always_comb begin
    wr_cnt = (32'(req_data_i.entry_var_count) > VARS_PER_MSG) ? VC_W'(VARS_PER_MSG)
                                                             : VC_W'(req_data_i.entry_var_count);
    msg_we = cmd_i.accept && (req_data_i.req_type == csu_pkg::REQ_MSG_WR)
             && (32'(req_data_i.slot_index) < MSG_SLOTS);
    msg_wa = SLOT_W'(req_data_i.slot_index);
    msg_wd = {req_data_i.entry_id, req_data_i.entry_min_dlc, wr_cnt};
    var_we = cmd_i.accept && (req_data_i.req_type == csu_pkg::REQ_VAR_WR)
             && (32'(req_data_i.slot_index) < MSG_SLOTS)
             && (32'(req_data_i.var_position) < VARS_PER_MSG);
    var_wa = VA_W'(req_data_i.slot_index) * VA_W'(VARS_PER_MSG)
             + VA_W'(req_data_i.var_position);
  end

  assign msg_ra = (32'(srch_idx_q) < MSG_SLOTS) ? SLOT_W'(srch_idx_q) : '0;
  assign var_ra = VA_W'(hit_idx_q) * VA_W'(VARS_PER_MSG) + VA_W'(v_q);

  always_ff @(posedge clk_i) begin
    if (msg_we) begin
      msg_mem[msg_wa] <= msg_wd;
    end
    msg_rd_q <= msg_mem[msg_ra];
  end

  always_ff @(posedge clk_i) begin
    if (var_we) begin
      var_mem[var_wa] <= {req_data_i.entry_start_bit, req_data_i.entry_type};
    end
    var_rd_q <= var_mem[var_ra];
  end

  // slot entry and descriptor decode
  assign rd_id   = msg_rd_q[MSG_W-1 -: csu_pkg::ID_W];
  assign rd_dlc  = msg_rd_q[VC_W +: csu_pkg::DLC_W];
  assign rd_cnt  = msg_rd_q[VC_W-1:0];
  assign target  = offset_q + OFF_W'(v_q);
  assign shifted = frm_data_q >> var_rd_q[VAR_W-1 -: csu_pkg::START_W];

  always_comb begin
    kind_ok = 1'b1;
    ext_val = '0;
    case (var_rd_q[csu_pkg::KIND_W-1:0])
      csu_pkg::KIND_BOOL:  ext_val = {31'b0, shifted[0]};
      csu_pkg::KIND_INT8:  ext_val = {24'b0, shifted[7:0]};
      csu_pkg::KIND_INT16: ext_val = {16'b0, shifted[15:0]};
      csu_pkg::KIND_INT32: ext_val = shifted[31:0];
      csu_pkg::KIND_FLOAT: ext_val = shifted[31:0];
      default:             kind_ok = 1'b0;
    endcase
  end

  assign out_free = !out_valid_q || res_ready_i;

  always_comb begin
    sts_o.srch_end   = (32'(cur_idx_q) >= 32'(msg_count_q)) || (32'(cur_idx_q) >= MSG_SLOTS);
    sts_o.match      = (rd_id == frm_id_q);
    sts_o.too_short  = (rd_dlc != '0) && (frm_dlc_q < rd_dlc);
    sts_o.emit_end   = (v_q >= hit_cnt_q)
                       || (CMP_W'(target) >= CMP_W'(VAR_STORE_SIZE))
                       || (32'(n_q) >= csu_pkg::MAX_RESULTS);
    sts_o.kind_ok    = kind_ok;
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
  end

  // next state of search, emission and output
  always_comb begin
    srch_idx_d   = srch_idx_q;
    offset_d     = offset_q;
    v_d          = v_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;

    if (cmd_i.accept) begin
      srch_idx_d   = '0;
      offset_d     = OFF_W'(var_base_q);
      n_d          = '0;
      pend_valid_d = 1'b0;
    end
    // first read of the slot table, nothing to add to the offset yet
    if (cmd_i.srch_open) begin
      srch_idx_d = srch_idx_q + 1'b1;
    end
    if (cmd_i.srch_step) begin
      srch_idx_d = srch_idx_q + 1'b1;
      offset_d   = offset_q + OFF_W'(rd_cnt);
    end
    if (cmd_i.hit_load) begin
      v_d = '0;
    end
    if (cmd_i.var_step) begin
      v_d = v_q + 1'b1;
    end

    if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.stage) begin
      n_d          = n_q + 1'b1;
      pend_valid_d = 1'b1;
      if (pend_valid_q && out_free) begin
        out_valid_d = 1'b1;
        out_d       = '{status: csu_pkg::ST_VAR_WRITTEN, var_index: pend_idx_q,
                        var_value: pend_val_q, var_kind: pend_kind_q, last: 1'b0};
      end
    end
    if (cmd_i.finish && out_free) begin
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
      if (pend_valid_q) begin
        out_d = '{status: csu_pkg::ST_VAR_WRITTEN, var_index: pend_idx_q,
                  var_value: pend_val_q, var_kind: pend_kind_q, last: 1'b1};
      end else begin
        out_d = '{status: cmd_i.resp_status, var_index: '0, var_value: '0,
                  var_kind: '0, last: 1'b1};
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_base_q   <= '0;
      msg_count_q  <= '0;
      srch_idx_q   <= '0;
      cur_idx_q    <= '0;
      v_q          <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          csu_pkg::CFG_VAR_BASE:  var_base_q  <= cfg_wdata_i[csu_pkg::VAR_BASE_W-1:0];
          csu_pkg::CFG_MSG_COUNT: msg_count_q <= cfg_wdata_i[csu_pkg::MSG_COUNT_W-1:0];
          default: ;
        endcase
      end
      srch_idx_q   <= srch_idx_d;
      cur_idx_q    <= srch_idx_q;
      v_q          <= v_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      frm_id_q   <= req_data_i.frame_id;
      frm_dlc_q  <= req_data_i.frame_dlc;
      frm_data_q <= req_data_i.frame_data;
    end
    if (cmd_i.hit_load) begin
      hit_idx_q <= SLOT_W'(cur_idx_q);
      hit_cnt_q <= rd_cnt;
    end
    if (cmd_i.stage) begin
      pend_idx_q  <= target[csu_pkg::VIDX_W-1:0];
      pend_val_q  <= ext_val;
      pend_kind_q <= var_rd_q[csu_pkg::KIND_W-1:0];
    end
    offset_q <= offset_d;
    out_q    <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_data_o  = out_q;

  `CSU_ASSERT_NXT(a_finish_last, cmd_i.finish && out_free, res_valid_o && res_data_o.last, "closing beat of an item lost its last flag")
  `CSU_ASSERT_IMP(a_stage_bound, cmd_i.stage, 32'(n_q) < csu_pkg::MAX_RESULTS, "more results staged than one item may give")

endmodule
